@@ src/pca_pkg.sv @@
// ---------------------------------------------------------------------------
// pca_pkg: shared types and constants of the PCA counter/PWM block
// Holds register codes, clock source codes, prescale factors, the sequencer
// states and the structs that pass between the top level and the counter.
// ---------------------------------------------------------------------------
package pca_pkg;

    // Stream payload widths (fields packed from bit 0, padded to bytes).
    localparam int IN_W  = 32;
    localparam int OUT_W = 24;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_RUN_ENABLE   = 3'd0,
        REG_IDLE_STOP    = 3'd1,
        REG_CLOCK_SELECT = 3'd2,
        REG_COMPARE_MASK = 3'd3,
        REG_PWM_MASK     = 3'd4,
        REG_DUTY_RELOAD  = 3'd5
    } pca_reg_idx_t;

    // Count source codes.
    typedef enum logic [1:0] {
        CLK_OSC12  = 2'd0,
        CLK_OSC2   = 2'd1,
        CLK_TIMER0 = 2'd2,
        CLK_ECI    = 2'd3
    } pca_clk_sel_t;

    // Amount taken off the work count per counter increment.
    localparam logic [3:0] PRESCALE_12  = 4'd12;
    localparam logic [3:0] PRESCALE_2   = 4'd2;
    localparam logic [3:0] PRESCALE_ONE = 4'd1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } pca_state_t;

    // Control from the sequencer to the counter.
    typedef struct packed {
        logic advance;
        logic clear_flag;
    } pca_ctrl_t;

    // Static configuration seen by the counter.
    typedef struct packed {
        logic [1:0]  compare_mask;
        logic [1:0]  pwm_mask;
        logic [15:0] duty_reload;
    } pca_cfg_t;

    // Status from the counter back to the sequencer.
    typedef struct packed {
        logic [7:0] count_high;
        logic [7:0] count_low;
        logic       overflow_flag;
        logic [1:0] pins;
        logic       full;
    } pca_stat_t;

endpackage

@@ src/pca_cnt_pwm.sv @@
// ---------------------------------------------------------------------------
// pca_cnt_pwm: 16-bit counter with PWM compare and duty reload
// Performs one counter increment per cycle when told to, updates the PWM
// pins, reloads the duty bytes on a low-byte wrap and keeps the sticky flag.
// ---------------------------------------------------------------------------
module pca_cnt_pwm
    import pca_pkg::*;
#(
    parameter int MODULES = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  pca_ctrl_t ctrl,
    input  pca_cfg_t  cfg,
    output pca_stat_t stat
);

    // Only modules 0 and 1 have register bits; higher ones never act.
    localparam int ACTIVE = (MODULES < 2) ? MODULES : 2;

    logic [7:0] count_low_reg,  count_low_next;
    logic [7:0] count_high_reg, count_high_next;
    logic [7:0] duty_reg  [ACTIVE];
    logic [7:0] duty_next [ACTIVE];
    logic       flag_reg,  flag_next;
    logic [1:0] pins_reg,  pins_next;
    logic       full;
    logic [7:0] low_inc;

    // One increment: compare against the old duty, then reload on wrap.
    always_comb begin
        count_low_next  = count_low_reg;
        count_high_next = count_high_reg;
        duty_next       = duty_reg;
        flag_next       = flag_reg;
        pins_next       = pins_reg;
        full            = 1'b0;
        low_inc         = count_low_reg + 8'd1;
        if (ctrl.clear_flag) begin
            flag_next = 1'b0;
        end
        if (ctrl.advance) begin
            count_low_next = low_inc;
            for (int i = 0; i < ACTIVE; i++) begin
                if (cfg.compare_mask[i] && cfg.pwm_mask[i]) begin
                    pins_next[i] = (low_inc >= duty_reg[i]);
                end
            end
            if (low_inc == 8'd0) begin
                for (int i = 0; i < ACTIVE; i++) begin
                    if (cfg.pwm_mask[i]) begin
                        duty_next[i] = cfg.duty_reload[8*i +: 8];
                    end
                end
                count_high_next = count_high_reg + 8'd1;
                if (count_high_next == 8'd0) begin
                    flag_next = 1'b1;
                    full      = 1'b1;
                end
            end
        end
    end

    // Counter state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_low_reg  <= '0;
            count_high_reg <= '0;
            flag_reg       <= 1'b0;
            pins_reg       <= 2'b11;
            for (int i = 0; i < ACTIVE; i++) begin
                duty_reg[i] <= '0;
            end
        end else begin
            count_low_reg  <= count_low_next;
            count_high_reg <= count_high_next;
            flag_reg       <= flag_next;
            pins_reg       <= pins_next;
            duty_reg       <= duty_next;
        end
    end

    assign stat.count_high    = count_high_reg;
    assign stat.count_low     = count_low_reg;
    assign stat.overflow_flag = flag_reg;
    assign stat.pins          = pins_reg;
    assign stat.full          = full;

endmodule

@@ src/pca_counter_pwm_prescaled.sv @@
// ---------------------------------------------------------------------------
// pca_counter_pwm_prescaled: PCA counter and PWM array with prescaler
// Counts oscillator, timer-0 or external events into a 16-bit counter and
// drives PWM pins; returns one status beat per tick beat.
// ---------------------------------------------------------------------------
// An accepted tick beat is worked off one counter increment per cycle: a
// shared subtract-and-compare unit takes the prescale factor (12, 2 or 1)
// off a 9-bit work count each cycle and advances the counter once. A
// halted or stopped counter loads a zero work count and makes no increment.
// s_tready is low while the increments run. The status beat sits in an
// output register, so the next tick is taken while it waits on m_tready.
// Configuration writes are always taken and must arrive only while idle.
// ---------------------------------------------------------------------------
module pca_counter_pwm_prescaled
    import pca_pkg::*;
#(
    parameter int MODULES = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    // s_tdata: osc_clocks[7:0], timer0_overflows[15:8], eci_edges[23:16],
    //          cpu_idle[24], clear_flag[25], zero padding[31:26]
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    // m_tdata: count_value[15:0], overflow_flag[16], pwm_pins[18:17],
    //          overflowed_now[19], zero padding[23:20]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    // Configuration registers.
    logic         run_en_reg;
    logic         idle_stop_reg;
    pca_clk_sel_t clk_sel_reg;
    logic [1:0]   cmp_mask_reg;
    logic [1:0]   pwm_mask_reg;
    logic [15:0]  duty_reload_reg;

    // Sequencer and work registers.
    pca_state_t state_reg, state_next;
    logic [8:0] work_reg,   work_next;
    logic [3:0] div_reg,    div_next;
    logic [3:0] rem_reg,    rem_next;
    logic       rem_wr_reg, rem_wr_next;
    logic       now_reg,    now_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg,  m_tdata_next;

    logic       in_accept;
    logic       step_ok;
    logic       out_load;
    logic       running;
    logic [8:0] load_work;
    logic [3:0] load_div;
    logic       load_rem_wr;
    pca_ctrl_t  ctrl;
    pca_cfg_t   cnt_cfg;
    pca_stat_t  stat;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_en_reg      <= 1'b0;
            idle_stop_reg   <= 1'b0;
            clk_sel_reg     <= CLK_OSC12;
            cmp_mask_reg    <= '0;
            pwm_mask_reg    <= '0;
            duty_reload_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RUN_ENABLE:   run_en_reg      <= cfg_data[0];
                REG_IDLE_STOP:    idle_stop_reg   <= cfg_data[0];
                REG_CLOCK_SELECT: clk_sel_reg     <= pca_clk_sel_t'(cfg_data[1:0]);
                REG_COMPARE_MASK: cmp_mask_reg    <= cfg_data[1:0];
                REG_PWM_MASK:     pwm_mask_reg    <= cfg_data[1:0];
                REG_DUTY_RELOAD:  duty_reload_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared unit: one prescale step is possible while work covers it.
    assign step_ok = (work_reg >= {5'b0, div_reg});

    // Work count, prescale factor and remainder handling chosen at accept.
    always_comb begin
        running     = run_en_reg && !(s_tdata[24] && idle_stop_reg);
        load_rem_wr = 1'b0;
        case (clk_sel_reg)
            CLK_OSC12: begin
                load_work   = {1'b0, s_tdata[7:0]} + {5'b0, rem_reg};
                load_div    = PRESCALE_12;
                load_rem_wr = 1'b1;
            end
            CLK_OSC2: begin
                load_work   = {1'b0, s_tdata[7:0]} + {5'b0, rem_reg};
                load_div    = PRESCALE_2;
                load_rem_wr = 1'b1;
            end
            CLK_TIMER0: begin
                load_work = {1'b0, s_tdata[15:8]};
                load_div  = PRESCALE_ONE;
            end
            default: begin
                load_work = {1'b0, s_tdata[23:16]};
                load_div  = PRESCALE_ONE;
            end
        endcase
        if (!running) begin
            load_work   = '0;
            load_div    = PRESCALE_ONE;
            load_rem_wr = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_RUN;
            ST_RUN:  if (!step_ok) state_next = ST_OUT;
            ST_OUT:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready        = 1'b0;
        ctrl.advance    = 1'b0;
        ctrl.clear_flag = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                ctrl.clear_flag = s_tvalid && s_tdata[25];
            end
            ST_RUN:  ctrl.advance = step_ok;
            ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    // Work datapath and result register.
    always_comb begin
        work_next     = work_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        rem_wr_next   = rem_wr_reg;
        now_next      = now_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (in_accept) begin
            work_next   = load_work;
            div_next    = load_div;
            rem_wr_next = load_rem_wr;
            now_next    = 1'b0;
        end
        if (ctrl.advance) begin
            work_next = work_reg - {5'b0, div_reg};
            now_next  = now_reg | stat.full;
        end
        // The leftover of an oscillator source is below its factor.
        if (state_reg == ST_RUN && !step_ok && rem_wr_reg) begin
            rem_next = work_reg[3:0];
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, now_reg, stat.pins, stat.overflow_flag,
                             stat.count_high, stat.count_low};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rem_reg      <= '0;
            rem_wr_reg   <= 1'b0;
            now_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            work_reg     <= '0;
            div_reg      <= PRESCALE_ONE;
        end else begin
            state_reg    <= state_next;
            rem_reg      <= rem_next;
            rem_wr_reg   <= rem_wr_next;
            now_reg      <= now_next;
            m_tvalid_reg <= m_tvalid_next;
            work_reg     <= work_next;
            div_reg      <= div_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cnt_cfg.compare_mask = cmp_mask_reg;
    assign cnt_cfg.pwm_mask     = pwm_mask_reg;
    assign cnt_cfg.duty_reload  = duty_reload_reg;

    // Counter, PWM compare and duty reload.
    pca_cnt_pwm #(
        .MODULES (MODULES)
    ) u_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .cfg     (cnt_cfg),
        .stat    (stat)
    );

endmodule

@@ src/pca_checker.sv @@
// ---------------------------------------------------------------------------
// pca_checker: port-level checks for the PCA counter/PWM block
// Watches the stream ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module pca_checker
    import pca_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // A stalled status beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("status beat changed while stalled");

    // No status beat comes out right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("status beat valid after reset");

    // An overflow in this item always leaves the sticky flag set.
    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[16])
        else $error("overflow reported without sticky flag");

    // One item at a time: the input closes after a tick is taken.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second tick taken while one is in work");

endmodule

bind pca_counter_pwm_prescaled pca_checker u_pca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
